// File: design/can_rx_filter_queue_macros.svh
// Assertion helpers for the CAN receive filter queue.
`ifndef CAN_RX_FILTER_QUEUE_MACROS_SVH
`define CAN_RX_FILTER_QUEUE_MACROS_SVH

`ifndef SYNTH
// antecedent |-> consequent, same cycle
`define CRFQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// antecedent |=> consequent, next cycle
`define CRFQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CRFQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define CRFQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// File: design/crfq_pkg.sv
`timescale 1ns / 1ps

package crfq_pkg;

   localparam int ID_W      = 11;
   localparam int HDR_W     = 8;
   localparam int DLC_W     = 4;
   localparam int SIZE_W    = 3;
   localparam int BYTES_W   = 64;
   localparam int PAYLOAD_W = 56;
   localparam int ACNT_W    = 3;
   localparam int HCNT_W    = 4;
   localparam int META_W    = ID_W + HDR_W + SIZE_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [DLC_W-1:0] MAX_DLC = 4'd8;

   localparam int DEF_RING_DEPTH    = 16;
   localparam int DEF_ADDRESS_SLOTS = 4;
   localparam int DEF_HEADER_SLOTS  = 8;

   localparam logic ACT_OFFER = 1'b0;
   localparam logic ACT_POP   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS_TABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_TABLE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_COUNT  = 2'd3;

   // classified transaction handed from front to back
   typedef struct packed {
      logic                 is_pop;
      logic                 pass;
      logic [ID_W-1:0]      id;
      logic [HDR_W-1:0]     hdr;
      logic [SIZE_W-1:0]    size;
      logic [PAYLOAD_W-1:0] payload;
   } cmd_type;

   typedef struct packed {
      logic                 accepted;
      logic                 dropped_full;
      logic                 message_valid;
      logic [ID_W-1:0]      receiver;
      logic [HDR_W-1:0]     header;
      logic [SIZE_W-1:0]    payload_size;
      logic [PAYLOAD_W-1:0] payload;
   } rsp_type;

   typedef enum logic {
      BK_IDLE,
      BK_READ
   } back_state_type;

endpackage

// File: design/can_rx_filter_queue.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// request   in         push / full           req_action, req_can_id, req_frame_length,
//                                            req_frame_bytes
// response  out        empty / pop           rsp_accepted ... rsp_stored_count
// csr       in         csr_write_en          csr_index, csr_wdata
//
// The front takes a transaction into a two-deep command queue in the cycle of push.
// The back works one command at a time: an offer or an empty pop is done in BK_IDLE,
// a pop of a stored message goes through BK_IDLE then BK_READ (registered ring read).
// A result waits in the output register; the back stalls only while that register is full.
// Synchronous reset clears pointers, counts and queues; ring contents are not cleared.

module can_rx_filter_queue #(
   parameter int RING_DEPTH    = crfq_pkg::DEF_RING_DEPTH,
   parameter int ADDRESS_SLOTS = crfq_pkg::DEF_ADDRESS_SLOTS,
   parameter int HEADER_SLOTS  = crfq_pkg::DEF_HEADER_SLOTS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   output logic                                   full,
   input  logic                                   req_action,
   input  logic [crfq_pkg::ID_W-1:0]              req_can_id,
   input  logic [crfq_pkg::DLC_W-1:0]             req_frame_length,
   input  logic [crfq_pkg::BYTES_W-1:0]           req_frame_bytes,
   output logic                                   empty,
   input  logic                                   pop,
   output logic                                   rsp_accepted,
   output logic                                   rsp_dropped_full,
   output logic                                   rsp_message_valid,
   output logic [crfq_pkg::ID_W-1:0]              rsp_receiver,
   output logic [crfq_pkg::HDR_W-1:0]             rsp_header,
   output logic [crfq_pkg::SIZE_W-1:0]            rsp_payload_size,
   output logic [crfq_pkg::PAYLOAD_W-1:0]         rsp_payload,
   output logic [$clog2(RING_DEPTH)-1:0]          rsp_stored_count,
   input  logic                                   csr_write_en,
   input  logic [crfq_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [((11*ADDRESS_SLOTS > 8*HEADER_SLOTS) ?
                  11*ADDRESS_SLOTS : 8*HEADER_SLOTS)-1:0] csr_wdata
);

   import crfq_pkg::*;

   localparam int AT_W = ID_W * ADDRESS_SLOTS;
   localparam int HT_W = HDR_W * HEADER_SLOTS;

   logic [AT_W-1:0]   address_table_ff;
   logic [ACNT_W-1:0] address_count_ff;
   logic [HT_W-1:0]   header_table_ff;
   logic [HCNT_W-1:0] header_count_ff;

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;
   rsp_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         address_table_ff <= '0;
         address_count_ff <= '0;
         header_table_ff  <= '0;
         header_count_ff  <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ADDRESS_TABLE: address_table_ff <= csr_wdata[AT_W-1:0];
            CSR_ADDRESS_COUNT: address_count_ff <= csr_wdata[ACNT_W-1:0];
            CSR_HEADER_TABLE:  header_table_ff  <= csr_wdata[HT_W-1:0];
            CSR_HEADER_COUNT:  header_count_ff  <= csr_wdata[HCNT_W-1:0];
            default: ;
         endcase
      end
   end

   crfq_front #(
      .ADDRESS_SLOTS (ADDRESS_SLOTS),
      .HEADER_SLOTS  (HEADER_SLOTS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .action        (req_action),
      .can_id        (req_can_id),
      .frame_length  (req_frame_length),
      .frame_bytes   (req_frame_bytes),
      .address_table (address_table_ff),
      .address_count (address_count_ff),
      .header_table  (header_table_ff),
      .header_count  (header_count_ff),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_take      (cmd_take)
   );

   crfq_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_take     (cmd_take),
      .empty        (empty),
      .pop          (pop),
      .rsp          (rsp),
      .stored_count (rsp_stored_count)
   );

   assign rsp_accepted      = rsp.accepted;
   assign rsp_dropped_full  = rsp.dropped_full;
   assign rsp_message_valid = rsp.message_valid;
   assign rsp_receiver      = rsp.receiver;
   assign rsp_header        = rsp.header;
   assign rsp_payload_size  = rsp.payload_size;
   assign rsp_payload       = rsp.payload;

endmodule

// File: design/crfq_ram.sv
`timescale 1ns / 1ps

module crfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/crfq_front.sv
`timescale 1ns / 1ps

module crfq_front #(
   parameter int ADDRESS_SLOTS = crfq_pkg::DEF_ADDRESS_SLOTS,
   parameter int HEADER_SLOTS  = crfq_pkg::DEF_HEADER_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic                              action,
   input  logic [crfq_pkg::ID_W-1:0]         can_id,
   input  logic [crfq_pkg::DLC_W-1:0]        frame_length,
   input  logic [crfq_pkg::BYTES_W-1:0]      frame_bytes,
   input  logic [11*ADDRESS_SLOTS-1:0]       address_table,
   input  logic [crfq_pkg::ACNT_W-1:0]       address_count,
   input  logic [8*HEADER_SLOTS-1:0]         header_table,
   input  logic [crfq_pkg::HCNT_W-1:0]       header_count,
   output logic                              cmd_valid,
   output crfq_pkg::cmd_type                 cmd,
   input  logic                              cmd_take
);

   import crfq_pkg::*;

   `include "can_rx_filter_queue_macros.svh"

   cmd_type          q_ff [2];
   logic             head_ff, head_in;
   logic             tail_ff, tail_in;
   logic [1:0]       cnt_ff, cnt_in;

   cmd_type          new_cmd;
   logic [DLC_W-1:0] dlc;
   logic [SIZE_W-1:0] n;
   logic             addr_ok, hdr_ok;
   logic [PAYLOAD_W-1:0] body;
   logic             push_ok;

   // filter and payload trimming
   always_comb begin
      dlc     = (frame_length > MAX_DLC) ? MAX_DLC : frame_length;
      n       = SIZE_W'(dlc - DLC_W'(1));
      body    = frame_bytes[BYTES_W-1:HDR_W];
      addr_ok = 1'b0;
      hdr_ok  = 1'b0;
      // slot k is live when k < count; counts above the slot total saturate naturally
      for (int k = 0; k < ADDRESS_SLOTS; k++) begin
         if ((ACNT_W'(k) < address_count) && (address_table[11*k +: ID_W] == can_id)) begin
            addr_ok = 1'b1;
         end
      end
      for (int k = 0; k < HEADER_SLOTS; k++) begin
         if ((HCNT_W'(k) < header_count) &&
             (header_table[8*k +: HDR_W] == frame_bytes[HDR_W-1:0])) begin
            hdr_ok = 1'b1;
         end
      end
      new_cmd.is_pop  = (action == ACT_POP);
      new_cmd.pass    = (dlc != '0) && addr_ok && hdr_ok;
      new_cmd.id      = can_id;
      new_cmd.hdr     = frame_bytes[HDR_W-1:0];
      new_cmd.size    = n;
      new_cmd.payload = '0;
      for (int i = 0; i < PAYLOAD_W / 8; i++) begin
         if (SIZE_W'(i) < n) begin
            new_cmd.payload[8*i +: 8] = body[8*i +: 8];
         end
      end
   end

   assign full      = (cnt_ff == 2'd2);
   assign push_ok   = push && !full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[head_ff];

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      if (push_ok) begin
         tail_in = ~tail_ff;
      end
      if (cmd_take && cmd_valid) begin
         head_in = ~head_ff;
      end
      case ({push_ok, cmd_take && cmd_valid})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 1'b0;
         tail_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[tail_ff] <= new_cmd;
      end
   end

   `CRFQ_ASSERT_IMPL(a_q_bound, clock, reset, 1'b1, cnt_ff != 2'd3, "command queue overflow")
   `CRFQ_ASSERT_NEXT(a_q_grow, clock, reset, push_ok && !cmd_take, cnt_ff == $past(cnt_ff) + 2'd1, "command queue count lost a push")

endmodule

// File: design/crfq_back.sv
`timescale 1ns / 1ps

module crfq_back #(
   parameter int RING_DEPTH = crfq_pkg::DEF_RING_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  crfq_pkg::cmd_type             cmd,
   output logic                          cmd_take,
   output logic                          empty,
   input  logic                          pop,
   output crfq_pkg::rsp_type             rsp,
   output logic [$clog2(RING_DEPTH)-1:0] stored_count
);

   import crfq_pkg::*;

   `include "can_rx_filter_queue_macros.svh"

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_DEPTH - 1);

   back_state_type   state_ff, state_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] count_ff, count_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;
   logic [PTR_W-1:0] out_cnt_ff, out_cnt_in;

   logic             out_free;
   logic             ring_full;
   logic             mem_we, mem_re;
   logic [META_W-1:0]    meta_rd;
   logic [PAYLOAD_W-1:0] payload_rd;

   assign out_free  = !out_valid_ff || pop;
   assign ring_full = (count_ff == LAST);

   always_comb begin
      state_in     = state_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !pop;
      out_in       = out_ff;
      out_cnt_in   = out_cnt_ff;
      cmd_take     = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_take = 1'b1;
               out_in   = '0;
               if (!cmd.is_pop) begin
                  out_valid_in = 1'b1;
                  if (cmd.pass && !ring_full) begin
                     mem_we          = 1'b1;
                     wr_ptr_in       = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
                     count_in        = count_ff + PTR_W'(1);
                     out_in.accepted = 1'b1;
                  end else if (cmd.pass) begin
                     out_in.dropped_full = 1'b1;
                  end
                  out_cnt_in = count_in;
               end else if (count_ff != '0) begin
                  // message comes back from the registered ring read in the next cycle, in BK_READ
                  mem_re    = 1'b1;
                  rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
                  count_in  = count_ff - PTR_W'(1);
                  state_in  = BK_READ;
               end else begin
                  out_valid_in = 1'b1;
                  out_cnt_in   = '0;
               end
            end
         end
         BK_READ: begin
            out_valid_in         = 1'b1;
            out_in               = '0;
            out_in.message_valid = 1'b1;
            out_in.receiver      = meta_rd[META_W-1 -: ID_W];
            out_in.header        = meta_rd[SIZE_W +: HDR_W];
            out_in.payload_size  = meta_rd[SIZE_W-1:0];
            out_in.payload       = payload_rd;
            out_cnt_in           = count_ff;
            state_in             = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff     <= out_in;
      out_cnt_ff <= out_cnt_in;
   end

   crfq_ram #(
      .WIDTH (META_W),
      .DEPTH (RING_DEPTH)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_ptr_ff),
      .wr_data ({cmd.id, cmd.hdr, cmd.size}),
      .rd_en   (mem_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (meta_rd)
   );

   crfq_ram #(
      .WIDTH (PAYLOAD_W),
      .DEPTH (RING_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (cmd.payload),
      .rd_en   (mem_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (payload_rd)
   );

   assign empty        = !out_valid_ff;
   assign rsp          = out_ff;
   assign stored_count = out_cnt_ff;

   `CRFQ_ASSERT_IMPL(a_read_slot_free, clock, reset, state_ff == BK_READ, !out_valid_ff, "ring read returned while result slot busy")
   `CRFQ_ASSERT_IMPL(a_flags_exclusive, clock, reset, out_valid_ff, $countones({out_ff.accepted, out_ff.dropped_full, out_ff.message_valid}) <= 1, "result carries conflicting flags")
   `CRFQ_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= LAST, "ring holds more than its depth allows")

endmodule

// File: bench/filter_queue_checker.sv
`timescale 1ns / 1ps

module filter_queue_checker (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             push,
   input  logic                                             full,
   input  logic                                             req_action,
   input  logic [crfq_pkg::ID_W-1:0]                        req_can_id,
   input  logic [crfq_pkg::DLC_W-1:0]                       req_frame_length,
   input  logic [crfq_pkg::BYTES_W-1:0]                     req_frame_bytes,
   input  logic                                             empty,
   input  logic                                             pop,
   input  logic                                             rsp_accepted,
   input  logic                                             rsp_dropped_full,
   input  logic                                             rsp_message_valid,
   input  logic [crfq_pkg::ID_W-1:0]                        rsp_receiver,
   input  logic [crfq_pkg::HDR_W-1:0]                       rsp_header,
   input  logic [crfq_pkg::SIZE_W-1:0]                      rsp_payload_size,
   input  logic [crfq_pkg::PAYLOAD_W-1:0]                   rsp_payload,
   input  logic [$clog2(crfq_pkg::DEF_RING_DEPTH)-1:0]      rsp_stored_count,
   input  logic                                             csr_write_en,
   input  logic [crfq_pkg::CSR_IDX_W-1:0]                   csr_index,
   input  logic [crfq_pkg::BYTES_W-1:0]                     csr_wdata,
   output int                                               fail_count,
   output int                                               pending
);

   import crfq_pkg::*;

   localparam int CNT_W = $clog2(DEF_RING_DEPTH);

   typedef struct packed {
      logic [ID_W-1:0]      id;
      logic [HDR_W-1:0]     hdr;
      logic [SIZE_W-1:0]    size;
      logic [PAYLOAD_W-1:0] payload;
   } stored_msg_type;

   typedef struct packed {
      rsp_type          msg;
      logic [CNT_W-1:0] count;
   } outcome_type;

   logic [11*DEF_ADDRESS_SLOTS-1:0] addr_table;
   logic [ACNT_W-1:0]               addr_count;
   logic [8*DEF_HEADER_SLOTS-1:0]   hdr_table;
   logic [HCNT_W-1:0]               hdr_count;

   stored_msg_type held_msgs[$];
   outcome_type    awaited_results[$];
   outcome_type    oldest;
   int             error_total = 0;

   assign fail_count = error_total;

   function automatic outcome_type filter_and_store(input logic act,
                                                    input logic [ID_W-1:0] id,
                                                    input logic [DLC_W-1:0] len,
                                                    input logic [BYTES_W-1:0] bytes);
      outcome_type    res;
      stored_msg_type ent;
      logic [DLC_W-1:0] dlc;
      logic [HDR_W-1:0] hdr;
      logic        addr_hit;
      logic        hdr_hit;
      int          n_addr;
      int          n_hdr;
      res      = '0;
      ent      = '0;
      addr_hit = 1'b0;
      hdr_hit  = 1'b0;
      if (act == ACT_OFFER) begin
         dlc    = (len > MAX_DLC) ? MAX_DLC : len;
         hdr    = bytes[7:0];
         n_addr = (addr_count > DEF_ADDRESS_SLOTS) ? DEF_ADDRESS_SLOTS : int'(addr_count);
         n_hdr  = (hdr_count > DEF_HEADER_SLOTS) ? DEF_HEADER_SLOTS : int'(hdr_count);
         for (int k = 0; k < n_addr; k++)
            if (addr_table[11*k +: 11] == id) addr_hit = 1'b1;
         for (int k = 0; k < n_hdr; k++)
            if (hdr_table[8*k +: 8] == hdr) hdr_hit = 1'b1;
         if (dlc != 0 && addr_hit && hdr_hit) begin
            // one slot stays free in the ring, so 15 held means full
            if (held_msgs.size() >= DEF_RING_DEPTH - 1) begin
               res.msg.dropped_full = 1'b1;
            end else begin
               ent.id   = id;
               ent.hdr  = hdr;
               ent.size = SIZE_W'(dlc - 4'd1);
               for (int i = 0; i < 7; i++)
                  if (i < int'(ent.size)) ent.payload[8*i +: 8] = bytes[8*i+8 +: 8];
               held_msgs.push_back(ent);
               res.msg.accepted = 1'b1;
            end
         end
      end else if (held_msgs.size() > 0) begin
         ent = held_msgs.pop_front();
         res.msg.message_valid = 1'b1;
         res.msg.receiver      = ent.id;
         res.msg.header        = ent.hdr;
         res.msg.payload_size  = ent.size;
         res.msg.payload       = ent.payload;
      end
      res.count = CNT_W'(held_msgs.size());
      return res;
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_total++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         addr_table = '0;
         addr_count = '0;
         hdr_table  = '0;
         hdr_count  = '0;
         held_msgs.delete();
         awaited_results.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_ADDRESS_TABLE: addr_table = csr_wdata[11*DEF_ADDRESS_SLOTS-1:0];
               CSR_ADDRESS_COUNT: addr_count = csr_wdata[ACNT_W-1:0];
               CSR_HEADER_TABLE:  hdr_table  = csr_wdata[8*DEF_HEADER_SLOTS-1:0];
               CSR_HEADER_COUNT:  hdr_count  = csr_wdata[HCNT_W-1:0];
               default: ;
            endcase
         end
         if (pop && !empty) begin
            if (awaited_results.size() == 0) begin
               $error("result transaction with nothing outstanding");
               error_total++;
            end else begin
               oldest = awaited_results.pop_front();
               compare_field("accepted", 64'(oldest.msg.accepted), 64'(rsp_accepted));
               compare_field("dropped_full", 64'(oldest.msg.dropped_full),
                             64'(rsp_dropped_full));
               compare_field("message_valid", 64'(oldest.msg.message_valid),
                             64'(rsp_message_valid));
               compare_field("receiver", 64'(oldest.msg.receiver), 64'(rsp_receiver));
               compare_field("header", 64'(oldest.msg.header), 64'(rsp_header));
               compare_field("payload_size", 64'(oldest.msg.payload_size),
                             64'(rsp_payload_size));
               compare_field("payload", 64'(oldest.msg.payload), 64'(rsp_payload));
               compare_field("stored_count", 64'(oldest.count), 64'(rsp_stored_count));
            end
         end
         if (push && !full)
            awaited_results.push_back(filter_and_store(req_action, req_can_id,
                                                       req_frame_length, req_frame_bytes));
      end
      pending <= awaited_results.size();
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import crfq_pkg::*;

   localparam int CSR_W = (11*DEF_ADDRESS_SLOTS > 8*DEF_HEADER_SLOTS) ?
                          11*DEF_ADDRESS_SLOTS : 8*DEF_HEADER_SLOTS;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 900;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   logic                 req_action = ACT_OFFER;
   logic [ID_W-1:0]      req_can_id = '0;
   logic [DLC_W-1:0]     req_frame_length = '0;
   logic [BYTES_W-1:0]   req_frame_bytes = '0;
   logic                 empty;
   logic                 pop = 1'b0;
   logic                 rsp_accepted;
   logic                 rsp_dropped_full;
   logic                 rsp_message_valid;
   logic [ID_W-1:0]      rsp_receiver;
   logic [HDR_W-1:0]     rsp_header;
   logic [SIZE_W-1:0]    rsp_payload_size;
   logic [PAYLOAD_W-1:0] rsp_payload;
   logic [$clog2(DEF_RING_DEPTH)-1:0] rsp_stored_count;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ADDRESS_TABLE;
   logic [CSR_W-1:0]     csr_wdata = '0;

   int fail_count;
   int pending;
   int stall_cycles = 0;
   int items_sent = 0;
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;

   // filter setup as last programmed, used to aim frames at the tables
   logic [43:0] cur_addr_tab;
   logic [63:0] cur_hdr_tab;
   int          cur_addr_used;
   int          cur_hdr_used;

   can_rx_filter_queue dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_action       (req_action),
      .req_can_id       (req_can_id),
      .req_frame_length (req_frame_length),
      .req_frame_bytes  (req_frame_bytes),
      .empty            (empty),
      .pop              (pop),
      .rsp_accepted     (rsp_accepted),
      .rsp_dropped_full (rsp_dropped_full),
      .rsp_message_valid(rsp_message_valid),
      .rsp_receiver     (rsp_receiver),
      .rsp_header       (rsp_header),
      .rsp_payload_size (rsp_payload_size),
      .rsp_payload      (rsp_payload),
      .rsp_stored_count (rsp_stored_count),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   filter_queue_checker chk (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_action       (req_action),
      .req_can_id       (req_can_id),
      .req_frame_length (req_frame_length),
      .req_frame_bytes  (req_frame_bytes),
      .empty            (empty),
      .pop              (pop),
      .rsp_accepted     (rsp_accepted),
      .rsp_dropped_full (rsp_dropped_full),
      .rsp_message_valid(rsp_message_valid),
      .rsp_receiver     (rsp_receiver),
      .rsp_header       (rsp_header),
      .rsp_payload_size (rsp_payload_size),
      .rsp_payload      (rsp_payload),
      .rsp_stored_count (rsp_stored_count),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || csr_write_en) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // result side: random stall before each transaction, none in steady phases
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = rsp_steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
      end
   end

   task automatic send_item(input logic act, input logic [ID_W-1:0] id,
                            input logic [DLC_W-1:0] len, input logic [BYTES_W-1:0] bytes);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push             <= 1'b1;
      req_action       <= act;
      req_can_id       <= id;
      req_frame_length <= len;
      req_frame_bytes  <= bytes;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
   endtask

   // upper data bits carry noise; the block must mask them off
   task automatic program_filter(input logic [43:0] at, input logic [ACNT_W-1:0] ac,
                                 input logic [63:0] ht, input logic [HCNT_W-1:0] hc);
      logic [CSR_W-1:0] data;
      wait_idle();
      data = {$urandom, $urandom};
      data[43:0] = at;
      write_reg(CSR_ADDRESS_TABLE, data);
      data = {$urandom, $urandom};
      data[ACNT_W-1:0] = ac;
      write_reg(CSR_ADDRESS_COUNT, data);
      write_reg(CSR_HEADER_TABLE, ht);
      data = {$urandom, $urandom};
      data[HCNT_W-1:0] = hc;
      write_reg(CSR_HEADER_COUNT, data);
      csr_write_en  <= 1'b0;
      cur_addr_tab  = at;
      cur_hdr_tab   = ht;
      cur_addr_used = (ac > DEF_ADDRESS_SLOTS) ? DEF_ADDRESS_SLOTS : int'(ac);
      cur_hdr_used  = (hc > DEF_HEADER_SLOTS) ? DEF_HEADER_SLOTS : int'(hc);
   endtask

   task automatic random_item(input int pop_pct);
      logic [BYTES_W-1:0] bytes;
      logic [ID_W-1:0]    id;
      logic [DLC_W-1:0]   len;
      int                 slot;
      bytes = {$urandom, $urandom};
      id    = ID_W'($urandom);
      len   = DLC_W'($urandom);
      if ($urandom_range(0, 99) < pop_pct) begin
         send_item(ACT_POP, id, len, bytes);
      end else if ($urandom_range(0, 9) < 8) begin
         // aimed at the tables; now and then at a slot past the count
         if ($urandom_range(0, 3) == 0 || cur_addr_used == 0) slot = $urandom_range(0, 3);
         else slot = $urandom_range(0, cur_addr_used - 1);
         id = cur_addr_tab[11*slot +: 11];
         if ($urandom_range(0, 3) == 0 || cur_hdr_used == 0) slot = $urandom_range(0, 7);
         else slot = $urandom_range(0, cur_hdr_used - 1);
         bytes[7:0] = cur_hdr_tab[8*slot +: 8];
         if ($urandom_range(0, 7) != 0) len = DLC_W'($urandom_range(1, 8));
         send_item(ACT_OFFER, id, len, bytes);
      end else begin
         send_item(ACT_OFFER, id, len, bytes);
      end
   endtask

   initial begin
      int phase_len;
      int pop_pct;
      logic [43:0] at;
      logic [63:0] ht;
      cur_addr_tab  = '0;
      cur_hdr_tab   = '0;
      cur_addr_used = 0;
      cur_hdr_used  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset filter rejects everything; pop on an empty ring
      send_item(ACT_OFFER, 11'h000, 4'd1, 64'h0);
      send_item(ACT_POP, 11'h7FF, 4'hF, {64{1'b1}});

      program_filter({11'h2AA, 11'h555, 11'h000, 11'h7FF}, 3'd4,
                     64'h66554433_221100FF, 4'd8);
      send_item(ACT_OFFER, 11'h7FF, 4'd8, {64{1'b1}});
      send_item(ACT_OFFER, 11'h000, 4'd1, 64'hDEADBEEF_CAFEF000);
      send_item(ACT_OFFER, 11'h555, 4'd15, 64'h01234567_89ABCDFF);   // long DLC clamps
      send_item(ACT_OFFER, 11'h2AA, 4'd9, 64'hFEDCBA98_76543200);
      send_item(ACT_OFFER, 11'h555, 4'd0, 64'h12345678_9ABCDEFF);    // zero DLC
      send_item(ACT_OFFER, 11'h123, 4'd4, 64'h11111111_111111FF);    // unknown id
      send_item(ACT_OFFER, 11'h7FF, 4'd4, 64'h22222222_2222225A);    // unknown header
      send_item(ACT_OFFER, 11'h7FF, 4'd3, 64'hA5A5A5A5_A5A5A522);    // junk past size
      repeat (7) send_item(ACT_POP, 11'h000, 4'd0, 64'h0);

      // counts above the slot numbers saturate
      program_filter({11'h001, 11'h002, 11'h004, 11'h7FE}, 3'd7,
                     64'h80402010_08040201, 4'd15);
      req_steady = 1'b1;
      repeat (17) send_item(ACT_OFFER, 11'h7FE, 4'd2, 64'h00000000_0000AA80);
      req_steady = 1'b0;
      send_item(ACT_POP, 11'h000, 4'd0, 64'h0);

      while (items_sent < RANDOM_ITEMS + 30) begin
         at = 44'({$urandom, $urandom});
         ht = {$urandom, $urandom};
         case ($urandom_range(0, 9))
            0:       program_filter(at, ACNT_W'($urandom_range(0, 7)), ht,
                                    HCNT_W'($urandom_range(0, 15)));
            1:       program_filter(at, 3'd7, ht, 4'd15);
            default: program_filter(at, ACNT_W'($urandom_range(1, 4)), ht,
                                    HCNT_W'($urandom_range(1, 8)));
         endcase
         case ($urandom_range(0, 2))
            0:       pop_pct = 15;
            1:       pop_pct = 40;
            default: pop_pct = 60;
         endcase
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         phase_len  = $urandom_range(30, 80);
         repeat (phase_len) random_item(pop_pct);
      end

      wait_idle();
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/crfq_pkg.sv
design/crfq_ram.sv
design/crfq_front.sv
design/crfq_back.sv
design/can_rx_filter_queue.sv
bench/filter_queue_checker.sv
bench/tb_top.sv
